@@ design/qpfi_pkg.sv @@
// ----------------------------------------------------------------------------
// qpfi_pkg
// Shared types, constants and tables of the pitch flip integrator.
// ----------------------------------------------------------------------------
package qpfi_pkg;

  // Component indexes of a quaternion.
  localparam logic [1:0] IdxX = 2'd0;
  localparam logic [1:0] IdxY = 2'd1;
  localparam logic [1:0] IdxZ = 2'd2;
  localparam logic [1:0] IdxW = 2'd3;

  // Configuration register indexes.
  localparam logic RegTorque = 1'b0;
  localparam logic RegAngle  = 1'b1;

  // Register reset values.
  localparam logic signed [15:0] TorqueReset = 16'sd4096;
  localparam logic [30:0]        AngleReset  = 31'd308831;

  // Output kinds.
  localparam logic KindFull    = 1'b0;
  localparam logic KindPartial = 1'b1;

  // One product term of the delta quaternion conj(prev) * cur.
  typedef struct packed {
    logic [1:0] p_idx;
    logic [1:0] c_idx;
    logic       neg;
    logic [1:0] dst;
  } term_t;

  // Term schedule: four terms for w, then x, y and z.
  function automatic term_t delta_term(input logic [3:0] s);
    term_t t;
    t = '0;
    case (s)
      4'd0:  t = '{IdxW, IdxW, 1'b0, IdxW};
      4'd1:  t = '{IdxX, IdxX, 1'b0, IdxW};
      4'd2:  t = '{IdxY, IdxY, 1'b0, IdxW};
      4'd3:  t = '{IdxZ, IdxZ, 1'b0, IdxW};
      4'd4:  t = '{IdxW, IdxX, 1'b0, IdxX};
      4'd5:  t = '{IdxX, IdxW, 1'b1, IdxX};
      4'd6:  t = '{IdxY, IdxZ, 1'b1, IdxX};
      4'd7:  t = '{IdxZ, IdxY, 1'b0, IdxX};
      4'd8:  t = '{IdxW, IdxY, 1'b0, IdxY};
      4'd9:  t = '{IdxX, IdxZ, 1'b0, IdxY};
      4'd10: t = '{IdxY, IdxW, 1'b1, IdxY};
      4'd11: t = '{IdxZ, IdxX, 1'b1, IdxY};
      4'd12: t = '{IdxW, IdxZ, 1'b0, IdxZ};
      4'd13: t = '{IdxX, IdxY, 1'b1, IdxZ};
      4'd14: t = '{IdxY, IdxX, 1'b0, IdxZ};
      default: t = '{IdxZ, IdxW, 1'b1, IdxZ};
    endcase
    return t;
  endfunction

  // Arctangent of 2^-i in Q2.30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    v = '0;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ design/quaternion_pitch_flip_integrator.sv @@
// ----------------------------------------------------------------------------
// quaternion_pitch_flip_integrator
// Integrates pitch from successive orientation quaternions and drives a flip.
// ----------------------------------------------------------------------------
// Flow: the first transaction after reset goes straight to the output register.
// A later one passes through the delta, scaling, root, CORDIC and division
// steps; a zero delta or a zero vector part skips ahead to the update. Both
// wait while the output slot stays full.
// One transaction at a time, the next taken the cycle after the
// result is registered. Reset loads the register defaults; once finished, inputs are dropped.
module quaternion_pitch_flip_integrator
  import qpfi_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // torque_pitch, pitch_total
  output logic        m_axis_tuser,   // adjust_kind
  output logic        m_axis_tlast    // finished
);

  // Sequencer states.
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDelta = 4'd1;
  localparam logic [3:0] StMax   = 4'd2;
  localparam logic [3:0] StNorm  = 4'd3;
  localparam logic [3:0] StNeg   = 4'd4;
  localparam logic [3:0] StSq    = 4'd5;
  localparam logic [3:0] StSqrt  = 4'd6;
  localparam logic [3:0] StCord  = 4'd7;
  localparam logic [3:0] StMulZ  = 4'd8;
  localparam logic [3:0] StDivI  = 4'd9;
  localparam logic [3:0] StDiv   = 4'd10;
  localparam logic [3:0] StUpd   = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;

  localparam logic [5:0] CordLast = 6'(CORDIC_STEPS - 1);

  logic [3:0]         st_q, st_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               started_q, started_d;
  logic               fin_q, fin_d;
  logic signed [15:0] torque_q, torque_d;
  logic [30:0]        angle_q, angle_d;
  logic signed [31:0] sum_q, sum_d;
  logic signed [15:0] cur_q [4];
  logic signed [15:0] cur_d [4];
  logic signed [15:0] prev_q [4];
  logic signed [15:0] prev_d [4];
  logic signed [33:0] dq_q [4];
  logic signed [33:0] dq_d [4];
  logic [33:0]        m_q, m_d;
  logic [63:0]        acc_q, acc_d;
  logic [63:0]        res_q, res_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic signed [63:0] prod_q;
  logic [45:0]        rem_q, rem_d;
  logic [19:0]        quo_q, quo_d;
  logic               neg_q, neg_d;
  logic signed [20:0] inc_q, inc_d;
  logic               ov_q, ov_d;
  logic               okind_q, okind_d;
  logic               olast_q, olast_d;
  logic signed [15:0] otorque_q, otorque_d;
  logic signed [31:0] ototal_q, ototal_d;

  // Shared multiplier operands and temporaries.
  logic signed [31:0] mul_a, mul_b;
  term_t              term_mul, term_acc;
  logic [33:0]        mag [4];
  logic [33:0]        mag_max;
  logic [63:0]        sq_bit, sq_try;
  logic signed [35:0] xs, ys;
  logic [63:0]        pmag, dividend;
  logic [45:0]        den;
  logic [46:0]        r2;
  logic signed [33:0] sat_sum;
  logic [32:0]        abs_sum;

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {ototal_q, otorque_q};

  // Shared multiplier operand selection.
  always_comb begin
    term_mul = delta_term(cnt_q[3:0]);
    term_acc = delta_term(cnt_q[3:0] - 4'd1);
    mul_a    = 32'(dq_q[cnt_q[1:0]]);
    mul_b    = 32'(dq_q[cnt_q[1:0]]);
    unique case (st_q)
      StDelta: begin
        mul_a = 32'(prev_q[term_mul.p_idx]);
        mul_b = 32'(cur_q[term_mul.c_idx]);
      end
      StMulZ: begin
        mul_a = z_q;
        mul_b = 32'(dq_q[IdxY]);
      end
      default: ;
    endcase
  end

  // Magnitudes for block normalization.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = dq_q[k][33] ? 34'(-dq_q[k]) : 34'(dq_q[k]);
    end
    mag_max = mag[0];
    for (int k = 1; k < 4; k++) begin
      if (mag[k] > mag_max) mag_max = mag[k];
    end
  end

  // Datapath helpers for root, CORDIC, division and update.
  always_comb begin
    sq_bit   = 64'd1 << {cnt_q[4:0], 1'b0};
    sq_try   = res_q + sq_bit;
    xs       = x_q >>> cnt_q;
    ys       = y_q >>> cnt_q;
    pmag     = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    dividend = {pmag[62:0], 1'b0} + {19'd0, res_q[31:0], 13'd0};
    den      = {res_q[31:0], 14'd0};
    r2       = {rem_q, quo_q[19]};
    sat_sum  = 34'(sum_q) + 34'(inc_q);
    abs_sum  = sum_q[31] ? 33'(-34'(sum_q)) : 33'(sum_q);
  end

  // Sequencer and next-state logic.
  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    fin_d     = fin_q;
    torque_d  = torque_q;
    angle_d   = angle_q;
    sum_d     = sum_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    dq_d      = dq_q;
    m_d       = m_q;
    acc_d     = acc_q;
    res_d     = res_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    inc_d     = inc_q;
    ov_d      = ov_q;
    okind_d   = okind_q;
    olast_d   = olast_q;
    otorque_d = otorque_q;
    ototal_d  = ototal_q;

    // Output register drains independently of the sequencer.
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTorque: torque_d = signed'(cfg_data_i[15:0]);
        RegAngle:  angle_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          for (int k = 0; k < 4; k++) cur_d[k] = signed'(s_axis_tdata[16*k +: 16]);
          if (fin_q) begin
            st_d = StIdle;
          end else if (!started_q) begin
            started_d = 1'b1;
            st_d      = StOut;
          end else begin
            for (int k = 0; k < 4; k++) dq_d[k] = '0;
            cnt_d = '0;
            st_d  = StDelta;
          end
        end
      end
      // Multiply one term per cycle, accumulate the previous one.
      StDelta: begin
        if (cnt_q != 6'd0) begin
          if (term_acc.neg) dq_d[term_acc.dst] = dq_q[term_acc.dst] - 34'(prod_q);
          else              dq_d[term_acc.dst] = dq_q[term_acc.dst] + 34'(prod_q);
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd16) st_d = StMax;
      end
      StMax: begin
        m_d = mag_max;
        if (mag_max == '0) begin
          inc_d = '0;
          st_d  = StUpd;
        end else begin
          st_d = StNorm;
        end
      end
      // One bit of power-of-two scaling per cycle.
      StNorm: begin
        if (m_q >= 34'd1 << 30) begin
          for (int k = 0; k < 4; k++) dq_d[k] = dq_q[k] >>> 1;
          m_d = m_q >> 1;
        end else if (m_q < 34'd1 << 29) begin
          for (int k = 0; k < 4; k++) dq_d[k] = dq_q[k] <<< 1;
          m_d = m_q << 1;
        end else begin
          st_d = StNeg;
        end
      end
      // Hemisphere hop.
      StNeg: begin
        if (dq_q[IdxW][33]) begin
          for (int k = 0; k < 4; k++) dq_d[k] = -dq_q[k];
        end
        acc_d = '0;
        cnt_d = '0;
        st_d  = StSq;
      end
      // Sum of squares of the vector part.
      StSq: begin
        if (cnt_q != 6'd0) acc_d = acc_q + 64'(prod_q);
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          res_d = '0;
          cnt_d = 6'd31;
          st_d  = StSqrt;
        end
      end
      // Bit-serial integer square root, two radicand bits per cycle.
      StSqrt: begin
        if (acc_q >= sq_try) begin
          acc_d = acc_q - sq_try;
          res_d = (res_q >> 1) + sq_bit;
        end else begin
          res_d = res_q >> 1;
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (res_d == '0) begin
            inc_d = '0;
            st_d  = StUpd;
          end else begin
            x_d   = 36'(dq_q[IdxW]);
            y_d   = signed'({4'd0, res_d[31:0]});
            z_d   = '0;
            cnt_d = '0;
            st_d  = StCord;
          end
        end
      end
      // Vectoring CORDIC, one rotation per cycle.
      StCord: begin
        if (y_q > 36'sd0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + signed'(atan_q30(cnt_q[4:0]));
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - signed'(atan_q30(cnt_q[4:0]));
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == CordLast) st_d = StMulZ;
      end
      StMulZ: begin
        st_d = StDivI;
      end
      // Rounded dividend; the quotient stays below 2^19.
      StDivI: begin
        neg_d = prod_q[63];
        rem_d = {2'd0, dividend[63:20]};
        quo_d = dividend[19:0];
        cnt_d = '0;
        st_d  = StDiv;
      end
      // Restoring division, one quotient bit per cycle.
      StDiv: begin
        if (r2 >= {1'b0, den}) begin
          rem_d = 46'(r2 - {1'b0, den});
          quo_d = {quo_q[18:0], 1'b1};
        end else begin
          rem_d = r2[45:0];
          quo_d = {quo_q[18:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd19) begin
          inc_d = neg_d ? -signed'({1'b0, quo_d}) : signed'({1'b0, quo_d});
          st_d  = StUpd;
        end
      end
      // Saturating accumulate.
      StUpd: begin
        if (sat_sum > 34'sd2147483647)       sum_d = 32'sh7FFFFFFF;
        else if (sat_sum < -34'sd2147483648) sum_d = 32'sh80000000;
        else                                 sum_d = 32'(sat_sum);
        st_d = StOut;
      end
      // Register the result once the output slot is free.
      StOut: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          ototal_d = sum_q;
          prev_d   = cur_q;
          if (abs_sum < {2'd0, angle_q}) begin
            okind_d   = KindFull;
            otorque_d = torque_q;
            olast_d   = 1'b0;
          end else begin
            okind_d   = KindPartial;
            otorque_d = '0;
            olast_d   = 1'b1;
            fin_d     = 1'b1;
          end
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      cnt_q     <= '0;
      started_q <= 1'b0;
      fin_q     <= 1'b0;
      torque_q  <= TorqueReset;
      angle_q   <= AngleReset;
      sum_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      fin_q     <= fin_d;
      torque_q  <= torque_d;
      angle_q   <= angle_d;
      sum_q     <= sum_d;
      ov_q      <= ov_d;
    end
  end

  // Datapath registers, including the shared multiplier's product.
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    dq_q      <= dq_d;
    m_q       <= m_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    prod_q    <= mul_a * mul_b;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    inc_q     <= inc_d;
    okind_q   <= okind_d;
    olast_q   <= olast_d;
    otorque_q <= otorque_d;
    ototal_q  <= ototal_d;
  end

  // A finishing result is always the partial, zero-torque kind.
  a_last_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser && m_axis_tdata[15:0] == '0))
    else $error("finishing result is not a zero partial adjustment");

  // Once finished, the flag stays set until reset.
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("finished flag dropped");

  // No new result is produced after the flip has ended.
  a_no_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(fin_q) && !$past(ov_q)) |-> !ov_q)
    else $error("result produced after finish");

  // The sequencer leaves idle only for an accepted transaction.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && !s_axis_tvalid) |=> st_q == StIdle)
    else $error("sequencer started without a transaction");

endmodule

@@ tb/tb_quaternion_pitch_flip_integrator.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_pitch_flip_integrator
// Drives orientation quaternions into the pitch flip integrator and checks
// every torque command against a bit-exact predictor of the integrated pitch,
// with random stalls on both streams and several register settings.
// ----------------------------------------------------------------------------
module tb_quaternion_pitch_flip_integrator;
  import qpfi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  Steps      = 16;
  localparam int  CycleLimit = 2000000;
  localparam int  SettleWait = 200;

  // One torque command as the block reports it.
  typedef struct {
    logic                kind;
    logic signed [15:0]  torque;
    logic                fin;
    logic signed [31:0]  total;
  } flip_cmd_t;

  // Predicts the commands of the flip integrator and checks them in order.
  class flip_tracker;
    logic signed [15:0] torque_reg;
    logic [30:0]        angle_reg;
    bit                 started;
    bit                 done;
    longint             prev_q[4];
    longint             sum;
    flip_cmd_t          pending_cmds[$];
    int                 errors;
    longint             atan_tab[16];

    function new();
      torque_reg = TorqueReset;
      angle_reg  = AngleReset;
      started    = 0;
      done       = 0;
      sum        = 0;
      errors     = 0;
      foreach (prev_q[k]) prev_q[k] = 0;
      atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                   64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                   64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                   64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    endfunction

    function void write_reg(logic idx, logic [30:0] data);
      if (idx == RegTorque) torque_reg = data[15:0];
      else angle_reg = data;
    endfunction

    // Floor square root of a nonnegative 64-bit value.
    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n   = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Pitch increment in Q15.16 for the rotation from prev_q to c.
    function longint pitch_step(longint c[4]);
      longint d[4];
      longint m;
      longint x, y, z, xs, ys, num, mg;
      longint unsigned vsq, vmag, den, q;
      d[3] = prev_q[3]*c[3] + prev_q[0]*c[0] + prev_q[1]*c[1] + prev_q[2]*c[2];
      d[0] = prev_q[3]*c[0] - prev_q[0]*c[3] - prev_q[1]*c[2] + prev_q[2]*c[1];
      d[1] = prev_q[3]*c[1] + prev_q[0]*c[2] - prev_q[1]*c[3] - prev_q[2]*c[0];
      d[2] = prev_q[3]*c[2] - prev_q[0]*c[1] + prev_q[1]*c[0] - prev_q[2]*c[3];
      m = 0;
      for (int k = 0; k < 4; k++) if ((d[k] < 0 ? -d[k] : d[k]) > m) m = d[k] < 0 ? -d[k] : d[k];
      if (m == 0) return 0;
      while (m >= (64'sd1 <<< 30)) begin
        for (int k = 0; k < 4; k++) d[k] = d[k] >>> 1;
        m = m >>> 1;
      end
      while (m < (64'sd1 <<< 29)) begin
        for (int k = 0; k < 4; k++) d[k] = d[k] * 2;
        m = m * 2;
      end
      // Hemisphere hop: keep the delta on the positive-w side.
      if (d[3] < 0) for (int k = 0; k < 4; k++) d[k] = -d[k];
      vsq  = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      vmag = root_floor(vsq);
      if (vmag == 0) return 0;
      // Vectoring CORDIC for atan2(|v|, w) in Q2.30.
      x = d[3];
      y = vmag;
      z = 0;
      for (int i = 0; i < Steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + atan_tab[i];
        end else begin
          x = x - ys; y = y + xs; z = z - atan_tab[i];
        end
      end
      num = 2 * z * d[1];
      den = vmag << 14;
      mg  = num < 0 ? -num : num;
      q   = (longint'(mg) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Notes one accepted orientation and queues the command it causes.
    function void note_orientation(logic [63:0] data);
      longint    c[4];
      longint    s;
      longint    mag;
      flip_cmd_t cmd;
      if (done) return;
      for (int k = 0; k < 4; k++) c[k] = longint'($signed(data[16*k +: 16]));
      if (!started) begin
        started = 1;
      end else begin
        s = sum + pitch_step(c);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        sum = s;
      end
      for (int k = 0; k < 4; k++) prev_q[k] = c[k];
      mag = sum < 0 ? -sum : sum;
      if (mag < longint'(angle_reg)) begin
        cmd.kind = KindFull; cmd.torque = torque_reg; cmd.fin = 1'b0;
      end else begin
        cmd.kind = KindPartial; cmd.torque = '0; cmd.fin = 1'b1;
        done = 1;
      end
      cmd.total = sum[31:0];
      pending_cmds.push_back(cmd);
    endfunction

    // Compares one received command with the oldest prediction.
    function void check_command(flip_cmd_t got);
      flip_cmd_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: kind %0d torque %0d total %0d",
               got.kind, got.torque, got.total);
        errors++;
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (got.kind !== exp_cmd.kind) begin
        $error("adjust_kind: expected %0d, actual %0d", exp_cmd.kind, got.kind);
        errors++;
      end
      if (got.torque !== exp_cmd.torque) begin
        $error("torque_pitch: expected %0d, actual %0d", exp_cmd.torque, got.torque);
        errors++;
      end
      if (got.fin !== exp_cmd.fin) begin
        $error("finished: expected %0d, actual %0d", exp_cmd.fin, got.fin);
        errors++;
      end
      if (got.total !== exp_cmd.total) begin
        $error("pitch_total: expected %0d, actual %0d", exp_cmd.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // quat_x, quat_y, quat_z, quat_w
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // torque_pitch, pitch_total
  logic        m_axis_tuser;    // adjust_kind
  logic        m_axis_tlast;    // finished

  flip_tracker tracker;
  bit          calm;
  int          cycles;
  logic [15:0] last_q[4];

  quaternion_pitch_flip_integrator #(.CORDIC_STEPS(Steps)) i_dut (.*);

  // Clock generation.
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stalls and result checking.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    flip_cmd_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.torque = m_axis_tdata[15:0];
      got.fin    = m_axis_tlast;
      got.total  = m_axis_tdata[47:16];
      tracker.check_command(got);
    end
  end

  // Writes one configuration register while the block is idle.
  task automatic write_reg(logic idx, logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits until every predicted command has arrived and the block is quiet.
  task automatic drain();
    while (tracker.pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  // Sends one orientation transaction, with an optional gap before it.
  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] w);
    int n;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_orientation(s_axis_tdata);
    last_q = '{x, y, z, w};
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] unit_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Random orientation: mostly in range, near the last one or fresh, with
  // some raw bit patterns mixed in.
  task automatic send_random();
    logic [15:0] q[4];
    int          mode;
    mode = $urandom_range(0, 15);
    for (int k = 0; k < 4; k++) begin
      if (mode == 0) q[k] = last_q[k];
      else if (mode < 8) q[k] = last_q[k] + 16'($signed($urandom_range(0, 64)) - 32);
      else if (mode < 14) q[k] = unit_comp();
      else q[k] = 16'($urandom);
    end
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  // Main stimulus sequence.
  initial begin
    tracker       = new();
    cycles        = 0;
    calm          = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegTorque;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    last_q        = '{16'h0, 16'h0, 16'h0, 16'h4000};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the widest angle and the most negative torque.
    write_reg(RegAngle, 31'h7FFFFFFF);
    write_reg(RegTorque, {15'h7ABC, 16'h8000});
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'hC000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'hC000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h2D41, 16'h0000, 16'h2D41);
    send_quat(16'h0000, 16'hD2BF, 16'h0000, 16'h2D41);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    send_quat(16'h0000, 16'h0001, 16'h0000, 16'h4000);
    send_quat(16'h0000, 16'h0001, 16'h0000, 16'h4000);
    send_quat(16'h2000, 16'hE000, 16'h2000, 16'hE000);
    send_quat(16'hC000, 16'h4000, 16'hC000, 16'h4000);
    send_quat(16'h0000, 16'h3FFF, 16'h0000, 16'h0100);

    // Random phases under different torques and angles.
    drain();
    write_reg(RegTorque, {15'h0000, 16'h7FFF});
    write_reg(RegAngle, 31'h40000000);
    repeat (800) send_random();
    drain();
    write_reg(RegTorque, {15'h1234, 16'h0000});
    write_reg(RegAngle, 31'h10000000 + 31'($urandom_range(0, 65535)));
    repeat (650) send_random();
    calm = 1;
    repeat (200) send_random();

    // Flip angle zero: the next transaction ends the flip, later ones drop.
    drain();
    write_reg(RegTorque, {15'h0000, 16'h1000});
    write_reg(RegAngle, 31'h0);
    repeat (6) send_random();

    drain();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
